>>> hdl/assert_macros.svh
// Assertion macros included by the cache unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge of i_clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The expression must never be true at a rising edge of i_clk outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

>>> hdl/lrukv_pkg.sv
package lrukv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DATA_W  = 32;

    localparam logic [CNT_W-1:0]  CAPACITY_RESET = CNT_W'(ENTRIES);
    localparam logic [DATA_W-1:0] MISS_VALUE     = '1;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef logic [DATA_W-1:0]              t_data;
    typedef logic [IDX_W-1:0]               t_idx;
    typedef logic [CNT_W-1:0]               t_cnt;
    typedef logic [ENTRIES-1:0][DATA_W-1:0] t_data_arr;
    typedef logic [ENTRIES-1:0][IDX_W-1:0]  t_rank_arr;

    typedef struct packed {
        logic hit;
        t_idx hit_idx;
        logic room;
        t_idx free_idx;
        t_idx victim_idx;
    } t_sel;

endpackage

>>> hdl/lrukv_sel.sv
module lrukv_sel (
    input  lrukv_pkg::t_data     i_key,
    input  lrukv_pkg::t_data_arr i_keys,
    input  logic [lrukv_pkg::ENTRIES-1:0] i_valid,
    input  lrukv_pkg::t_rank_arr i_rank,
    input  lrukv_pkg::t_cnt      i_filled,
    input  lrukv_pkg::t_cnt      i_capacity,
    output lrukv_pkg::t_sel      o_sel
);

    always_comb begin
        lrukv_pkg::t_cnt eff;
        lrukv_pkg::t_cnt last;
        o_sel = '0;
        eff   = i_capacity;
        if (eff == '0) begin
            eff = lrukv_pkg::t_cnt'(1);
        end else if (eff > lrukv_pkg::t_cnt'(lrukv_pkg::ENTRIES)) begin
            eff = lrukv_pkg::t_cnt'(lrukv_pkg::ENTRIES);
        end
        o_sel.room = (i_filled < eff);
        last       = i_filled - lrukv_pkg::t_cnt'(1);
        // Scan downward so that the lowest matching index wins.
        for (int i = lrukv_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_keys[i] == i_key)) begin
                o_sel.hit     = 1'b1;
                o_sel.hit_idx = lrukv_pkg::t_idx'(i);
            end
            if (!i_valid[i]) begin
                o_sel.free_idx = lrukv_pkg::t_idx'(i);
            end
            if (i_valid[i] && (i_rank[i] == last[lrukv_pkg::IDX_W-1:0])) begin
                o_sel.victim_idx = lrukv_pkg::t_idx'(i);
            end
        end
    end

endmodule

>>> hdl/lru_key_value_cache_unit.sv
// Channel   Handshake            Payload
// request   start / busy         i_kind, i_key, i_value
// result    o_done (strobe)      o_hit, o_read_value
// config    i_cfg_we             i_cfg_data (capacity)
//
// A request is registered when accepted and resolved in the next cycle, where a get's
// result is registered onto the outputs; one request per cycle while busy is low.
// The lookup, replacement choice and recency update run in that single stage.
// Reset is synchronous and active low; busy is high during reset and in the cycle after it.
// Results are strobed for exactly one cycle and cannot be held off; a put gives none.
`include "assert_macros.svh"

module lru_key_value_cache_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_kind,
    input  logic signed [31:0]          i_key,
    input  logic signed [31:0]          i_value,
    output logic                        o_done,
    output logic                        o_hit,
    output logic signed [31:0]          o_read_value,
    input  logic                        i_cfg_we,
    input  logic [4:0]                  i_cfg_data
);

    logic                                r_busy;
    logic                                r_vld;
    logic                                r_kind;
    lrukv_pkg::t_data                    r_key;
    lrukv_pkg::t_data                    r_value;
    lrukv_pkg::t_cnt                     r_capacity;
    lrukv_pkg::t_data_arr                r_keys;
    lrukv_pkg::t_data_arr                r_values;
    logic [lrukv_pkg::ENTRIES-1:0]       r_valid;
    lrukv_pkg::t_rank_arr                r_rank;
    lrukv_pkg::t_cnt                     r_filled;

    logic [lrukv_pkg::ENTRIES-1:0]       n_valid;
    lrukv_pkg::t_rank_arr                n_rank;
    lrukv_pkg::t_cnt                     n_filled;
    logic                                wr_en;
    lrukv_pkg::t_idx                     wr_idx;
    lrukv_pkg::t_sel                     sel;

    assign busy = r_busy | !i_rst_n;

    lrukv_sel u_sel (
        .i_key      (r_key),
        .i_keys     (r_keys),
        .i_valid    (r_valid),
        .i_rank     (r_rank),
        .i_filled   (r_filled),
        .i_capacity (r_capacity),
        .o_sel      (sel)
    );

    always_comb begin
        lrukv_pkg::t_idx thr;
        logic            age_all;
        logic            touch;
        lrukv_pkg::t_idx slot;
        n_valid  = r_valid;
        n_rank   = r_rank;
        n_filled = r_filled;
        wr_en    = 1'b0;
        age_all  = 1'b0;
        touch    = 1'b0;
        slot     = sel.hit_idx;
        thr      = r_rank[sel.hit_idx];
        if (r_vld) begin
            if (sel.hit) begin
                touch = 1'b1;
                wr_en = (r_kind == lrukv_pkg::KIND_PUT);
            end else if (r_kind == lrukv_pkg::KIND_PUT) begin
                touch = 1'b1;
                wr_en = 1'b1;
                if (sel.room) begin
                    age_all  = 1'b1;
                    slot     = sel.free_idx;
                    n_filled = r_filled + lrukv_pkg::t_cnt'(1);
                end else begin
                    slot = sel.victim_idx;
                    thr  = r_rank[sel.victim_idx];
                end
            end
        end
        if (touch) begin
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                if (r_valid[i] && (age_all || (r_rank[i] < thr))) begin
                    n_rank[i] = r_rank[i] + lrukv_pkg::t_idx'(1);
                end
            end
            n_rank[slot]  = '0;
            n_valid[slot] = 1'b1;
        end
        wr_idx = slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_vld      <= 1'b0;
            r_capacity <= lrukv_pkg::CAPACITY_RESET;
            r_valid    <= '0;
            r_rank     <= '0;
            r_filled   <= '0;
            o_done     <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_vld    <= start && !busy;
            r_valid  <= n_valid;
            r_rank   <= n_rank;
            r_filled <= n_filled;
            o_done   <= r_vld && (r_kind == lrukv_pkg::KIND_GET);
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (wr_en) begin
            r_keys[wr_idx]   <= r_key;
            r_values[wr_idx] <= r_value;
        end
        o_hit        <= sel.hit;
        o_read_value <= sel.hit ? r_values[sel.hit_idx] : lrukv_pkg::MISS_VALUE;
    end

    `ASSERT_CLK(a_done_from_get, o_done |-> $past(r_vld && (r_kind == lrukv_pkg::KIND_GET)), "result transfer without a get")
    `ASSERT_CLK(a_fill_matches_valid, $countones(r_valid) == int'(r_filled), "fill count differs from valid entries")
    `ASSERT_NEVER(a_fill_overflow, r_filled > lrukv_pkg::t_cnt'(lrukv_pkg::ENTRIES), "fill count above entry count")
    `ASSERT_CLK(a_put_keeps_hit, (r_vld && sel.hit) |=> (r_valid == $past(r_valid)), "hit changed the valid entries")

endmodule
